@@ rtl/spk_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spk_pkg
// Shared types and constants for the Speck round pipeline.
// ----------------------------------------------------------------------------
package spk_pkg;

	localparam int DEF_WORD_BITS  = 32;
	localparam int DEF_MAX_ROUNDS = 64;
	localparam int DEF_ROT_RIGHT  = 8;
	localparam int DEF_ROT_LEFT   = 3;

	localparam int FIELD_BITS     = 32;
	localparam int KEY_INDEX_BITS = 6;
	localparam int ROUNDS_BITS    = 7;
	localparam int APB_ADDR_BITS  = 3;
	localparam int APB_DATA_BITS  = 32;

	localparam logic [ROUNDS_BITS-1:0] RESET_ROUNDS = 7'd27;

	// Register index taken from paddr[2].
	localparam logic REG_ROUNDS = 1'b0;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_ENCRYPT = 2'd1,
		MODE_DECRYPT = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [KEY_INDEX_BITS-1:0] idx;
	} ctrl_t;

endpackage
`default_nettype wire

@@ rtl/spk_apb_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spk_apb_regs
// APB register file holding the number of rounds applied per block.
// ----------------------------------------------------------------------------
module spk_apb_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [spk_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [spk_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic      [spk_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                    pready,
	output logic      [spk_pkg::ROUNDS_BITS-1:0]    rounds
);

	logic [spk_pkg::ROUNDS_BITS-1:0] rounds_q;
	logic                            reg_sel;
	logic                            wr_en;

	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready && (reg_sel == spk_pkg::REG_ROUNDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounds_q <= spk_pkg::RESET_ROUNDS;
		end else if (wr_en) begin
			rounds_q <= pwdata[spk_pkg::ROUNDS_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == spk_pkg::REG_ROUNDS) begin
			prdata = spk_pkg::APB_DATA_BITS'(rounds_q);
		end
	end

	assign rounds = rounds_q;

endmodule
`default_nettype wire

@@ rtl/spk_round_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spk_round_stage
// One pipeline stage: a forward or inverse Speck round and its own key copies.
// ----------------------------------------------------------------------------
module spk_round_stage #(
	parameter int WORD_BITS  = spk_pkg::DEF_WORD_BITS,
	parameter int MAX_ROUNDS = spk_pkg::DEF_MAX_ROUNDS,
	parameter int ROT_RIGHT  = spk_pkg::DEF_ROT_RIGHT,
	parameter int ROT_LEFT   = spk_pkg::DEF_ROT_LEFT,
	parameter int STAGE      = 0
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            ce,
	input  wire logic [spk_pkg::ROUNDS_BITS-1:0] rounds,
	input  wire logic                            in_valid,
	input  wire spk_pkg::ctrl_t                  in_ctrl,
	input  wire logic [WORD_BITS-1:0]            in_x,
	input  wire logic [WORD_BITS-1:0]            in_y,
	output logic                                 out_valid,
	output spk_pkg::ctrl_t                       out_ctrl,
	output logic      [WORD_BITS-1:0]            out_x,
	output logic      [WORD_BITS-1:0]            out_y
);

	// Encryption uses key STAGE here; decryption runs the stages with keys in
	// reverse order, so this stage holds key MAX_ROUNDS-1-STAGE for it.
	localparam logic [spk_pkg::KEY_INDEX_BITS-1:0] ENC_IDX =
		spk_pkg::KEY_INDEX_BITS'(STAGE);
	localparam logic [spk_pkg::KEY_INDEX_BITS-1:0] DEC_IDX =
		spk_pkg::KEY_INDEX_BITS'(MAX_ROUNDS - 1 - STAGE);
	localparam logic [spk_pkg::ROUNDS_BITS-1:0] ENC_POS =
		spk_pkg::ROUNDS_BITS'(STAGE);
	localparam logic [spk_pkg::ROUNDS_BITS-1:0] DEC_POS =
		spk_pkg::ROUNDS_BITS'(MAX_ROUNDS - 1 - STAGE);

	logic [WORD_BITS-1:0] key_enc_q;
	logic [WORD_BITS-1:0] key_dec_q;

	logic                 valid_s1;
	spk_pkg::ctrl_t       ctrl_s1;
	logic [WORD_BITS-1:0] x_s1;
	logic [WORD_BITS-1:0] y_s1;

	logic                 is_load;
	logic                 enc_act;
	logic                 dec_act;
	logic [WORD_BITS-1:0] enc_x;
	logic [WORD_BITS-1:0] enc_y;
	logic [WORD_BITS-1:0] dec_x;
	logic [WORD_BITS-1:0] dec_y;
	logic [WORD_BITS-1:0] nxt_x;
	logic [WORD_BITS-1:0] nxt_y;

	assign is_load = in_valid && (in_ctrl.mode == spk_pkg::MODE_LOAD);
	assign enc_act = (in_ctrl.mode == spk_pkg::MODE_ENCRYPT) && (rounds > ENC_POS);
	assign dec_act = (in_ctrl.mode == spk_pkg::MODE_DECRYPT) && (rounds > DEC_POS);

	always_comb begin
		enc_x = ((in_x >> ROT_RIGHT) | (in_x << (WORD_BITS - ROT_RIGHT))) + in_y;
		enc_x = enc_x ^ key_enc_q;
		enc_y = ((in_y << ROT_LEFT) | (in_y >> (WORD_BITS - ROT_LEFT))) ^ enc_x;

		dec_y = ((in_x ^ in_y) >> ROT_LEFT) | ((in_x ^ in_y) << (WORD_BITS - ROT_LEFT));
		dec_x = (in_x ^ key_dec_q) - dec_y;
		dec_x = (dec_x << ROT_RIGHT) | (dec_x >> (WORD_BITS - ROT_RIGHT));

		nxt_x = in_x;
		nxt_y = in_y;
		if (enc_act) begin
			nxt_x = enc_x;
			nxt_y = enc_y;
		end else if (dec_act) begin
			nxt_x = dec_x;
			nxt_y = dec_y;
		end
	end

	// A load word carries its key in x and writes this stage's copies as it
	// passes, so every later block sees it and no earlier block does.
	always_ff @(posedge clk) begin
		if (ce && is_load) begin
			if (in_ctrl.idx == ENC_IDX) begin
				key_enc_q <= in_x;
			end
			if (in_ctrl.idx == DEC_IDX) begin
				key_dec_q <= in_x;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ctrl_s1 <= in_ctrl;
			x_s1    <= nxt_x;
			y_s1    <= nxt_y;
		end
	end

	assign out_valid = valid_s1;
	assign out_ctrl  = ctrl_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;

endmodule
`default_nettype wire

@@ rtl/speck_block_cipher_rounds_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// speck_block_cipher_rounds_core
// Speck round engine on loaded round keys, one round per pipeline stage.
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel. tuser selects the kind: load a
// round key, encrypt a block or decrypt a block. Loads give no output word;
// each encrypt or decrypt gives one word on m_axis holding out_x and out_y.
// The pipeline has an input register and MAX_ROUNDS round stages; every word
// runs through all of them, and stages beyond the configured round count
// pass the block through. An output word leaves the last round stage once it
// has passed the input register and every round stage. A new input word is
// taken in every cycle without a hold, whatever rounds_in_use is set to.
// Round keys live as per-stage copies that a load word writes as it moves
// down the pipeline, so keys and blocks keep their order exactly.
// Reset clears all valid bits and sets rounds_in_use to 27; the key copies
// are not cleared and must be loaded before use. When m_axis_tready is low
// with a word waiting, the whole pipeline holds and s_axis_tready drops;
// nothing is lost or repeated. The user must write rounds_in_use over APB at
// byte address 0 only while the engine idles; the block does not enforce it.
// ----------------------------------------------------------------------------
module speck_block_cipher_rounds_core #(
	parameter int WORD_BITS  = spk_pkg::DEF_WORD_BITS,
	parameter int MAX_ROUNDS = spk_pkg::DEF_MAX_ROUNDS,
	parameter int ROT_RIGHT  = spk_pkg::DEF_ROT_RIGHT,
	parameter int ROT_LEFT   = spk_pkg::DEF_ROT_LEFT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [spk_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [spk_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic      [spk_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                    pready,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// key_index[5:0], key_word[37:6], block_x[69:38], block_y[101:70], zero
	input  wire logic [103:0]                       s_axis_tdata,
	// mode[1:0]
	input  wire logic [1:0]                         s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// out_x[31:0], out_y[63:32]
	output logic      [63:0]                        m_axis_tdata
);

	localparam int FB = spk_pkg::FIELD_BITS;
	localparam int KB = spk_pkg::KEY_INDEX_BITS;

	logic [spk_pkg::ROUNDS_BITS-1:0] rounds;
	logic                            ce;

	logic           pipe_valid [MAX_ROUNDS+1];
	spk_pkg::ctrl_t pipe_ctrl  [MAX_ROUNDS+1];
	logic [WORD_BITS-1:0] pipe_x [MAX_ROUNDS+1];
	logic [WORD_BITS-1:0] pipe_y [MAX_ROUNDS+1];

	logic                 valid_s0;
	spk_pkg::ctrl_t       ctrl_s0;
	logic [WORD_BITS-1:0] x_s0;
	logic [WORD_BITS-1:0] y_s0;

	spk_pkg::mode_t       in_mode;
	logic                 in_known;
	logic [KB-1:0]        in_idx;
	logic [FB-1:0]        in_key;
	logic [FB-1:0]        in_bx;
	logic [FB-1:0]        in_by;

	spk_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rounds  (rounds)
	);

	assign in_mode  = spk_pkg::mode_t'(s_axis_tuser);
	assign in_idx   = s_axis_tdata[KB-1:0];
	assign in_key   = s_axis_tdata[KB +: FB];
	assign in_bx    = s_axis_tdata[KB+FB +: FB];
	assign in_by    = s_axis_tdata[KB+2*FB +: FB];
	// The unused mode code is taken and dropped.
	assign in_known = (in_mode == spk_pkg::MODE_LOAD) || (in_mode == spk_pkg::MODE_ENCRYPT)
		|| (in_mode == spk_pkg::MODE_DECRYPT);

	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (ce) begin
			valid_s0 <= s_axis_tvalid && in_known;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ctrl_s0.mode <= in_mode;
			ctrl_s0.idx  <= in_idx;
			x_s0         <= (in_mode == spk_pkg::MODE_LOAD) ? WORD_BITS'(in_key)
				: WORD_BITS'(in_bx);
			y_s0         <= WORD_BITS'(in_by);
		end
	end

	assign pipe_valid[0] = valid_s0;
	assign pipe_ctrl[0]  = ctrl_s0;
	assign pipe_x[0]     = x_s0;
	assign pipe_y[0]     = y_s0;

	for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_stage
		spk_round_stage #(
			.WORD_BITS  (WORD_BITS),
			.MAX_ROUNDS (MAX_ROUNDS),
			.ROT_RIGHT  (ROT_RIGHT),
			.ROT_LEFT   (ROT_LEFT),
			.STAGE      (g)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.ce        (ce),
			.rounds    (rounds),
			.in_valid  (pipe_valid[g]),
			.in_ctrl   (pipe_ctrl[g]),
			.in_x      (pipe_x[g]),
			.in_y      (pipe_y[g]),
			.out_valid (pipe_valid[g+1]),
			.out_ctrl  (pipe_ctrl[g+1]),
			.out_x     (pipe_x[g+1]),
			.out_y     (pipe_y[g+1])
		);
	end

	// Load words leave the last stage without producing an output word.
	assign m_axis_tvalid = pipe_valid[MAX_ROUNDS]
		&& (pipe_ctrl[MAX_ROUNDS].mode != spk_pkg::MODE_LOAD);
	assign m_axis_tdata  = {FB'(pipe_y[MAX_ROUNDS]), FB'(pipe_x[MAX_ROUNDS])};

endmodule
`default_nettype wire
